FILE: rtl/pressure_temperature_compensation_assert.svh
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
// clocked implication, disabled while reset is high
`define PTC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/ptc_pkg.sv
package ptc_pkg;

   localparam int RawWidth = 20;
   localparam int WordWidth = 32;
   localparam int CsrDataWidth = 64;
   localparam int CsrIndexWidth = 2;
   localparam int DivStages = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_TEMP_COEFFS = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_LOW = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_HIGH = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_NINE = 2'd3;

   typedef struct packed {
      logic [RawWidth-1:0] raw_temperature;
      logic [RawWidth-1:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] temperature_centi;
      logic [WordWidth-1:0] pressure_pa;
      logic divide_guard;
   } rsp_type;

   function automatic logic [31:0] sra(input logic [31:0] x, input int s);
      sra = 32'($signed(x) >>> s);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

endpackage

FILE: rtl/ptc_divider.sv
// unsigned 32/32 restoring divider, one quotient bit per stage
module ptc_divider (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] quotient
);
   import ptc_pkg::*;

   localparam int N = DivStages;

   logic [N-1:0][31:0] rem_ff, num_ff, den_ff;
   logic [N-1:0][31:0] rem_in, num_in;

   always_comb begin
      logic [32:0] trial;
      logic [31:0] r, n, dd;
      for (int s = 0; s < N; s++) begin
         r = (s == 0) ? 32'd0 : rem_ff[s-1];
         n = (s == 0) ? dividend : num_ff[s-1];
         dd = (s == 0) ? divisor : den_ff[s-1];
         trial = {r, n[31]} - {1'b0, dd};
         if (!trial[32]) begin
            rem_in[s] = trial[31:0];
            num_in[s] = {n[30:0], 1'b1};
         end else begin
            rem_in[s] = {r[30:0], n[31]};
            num_in[s] = {n[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         den_ff[0] <= divisor;
         for (int s = 1; s < N; s++) den_ff[s] <= den_ff[s-1];
      end
   end

   assign quotient = num_ff[N-1];
endmodule

FILE: rtl/pressure_temperature_compensation.sv
// Compensates one raw temperature/pressure pair per clock while the result
// is taken. Fully pipelined through the front section, the 32-stage
// divider and the back section; a new beat may be accepted in every cycle
// while the output is taken, and the divider is most of the pipeline length.
// The whole pipeline stalls together when the result is not taken. A zero
// divisor yields pressure 0 with divide_guard set. Calibration must be written
// via csr_ only while no beat is in flight; the block does not enforce it.
module pressure_temperature_compensation (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ptc_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ptc_pkg::rsp_type rsp_data,
   input  logic csr_write,
   input  logic [ptc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ptc_pkg::CsrDataWidth-1:0] csr_wdata
);
   import ptc_pkg::*;

   localparam int PreStages = 8;
   localparam int PostStages = 4;
   localparam int Depth = PreStages + DivStages + PostStages;

   logic [47:0] tc_ff;
   logic [63:0] pl_ff, ph_ff;
   logic [15:0] p9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff <= '0; pl_ff <= '0; ph_ff <= '0; p9_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TEMP_COEFFS: tc_ff <= csr_wdata[47:0];
            CSR_PRESS_LOW:   pl_ff <= csr_wdata;
            CSR_PRESS_HIGH:  ph_ff <= csr_wdata;
            CSR_PRESS_NINE:  p9_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'd0, tc_ff[15:0]};
   assign t2 = sx16(tc_ff[31:16]);
   assign t3 = sx16(tc_ff[47:32]);
   assign p1 = {16'd0, pl_ff[15:0]};
   assign p2 = sx16(pl_ff[31:16]);
   assign p3 = sx16(pl_ff[47:32]);
   assign p4 = sx16(pl_ff[63:48]);
   assign p5 = sx16(ph_ff[15:0]);
   assign p6 = sx16(ph_ff[31:16]);
   assign p7 = sx16(ph_ff[47:32]);
   assign p8 = sx16(ph_ff[63:48]);
   assign p9 = sx16(p9_ff);

   logic [Depth-1:0] vld_ff;
   logic advance;
   assign advance = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[Depth-2:0], req_valid};
   end

   // front section: temperature and divisor/dividend
   logic [31:0] s1_adcp_ff, s1_x_ff, s1_d_ff;
   logic [31:0] s2_adcp_ff, s2_a_ff, s2_dd_ff;
   logic [31:0] s3_adcp_ff, s3_a_ff, s3_b_ff;
   logic [31:0] s4_adcp_ff, s4_fine_ff, s4_t5_ff;
   logic [31:0] s5_adcp_ff, s5_temp_ff, s5_a_ff, s5_sq_ff;
   logic [31:0] s6_adcp_ff, s6_temp_ff, s6_b6_ff, s6_b5_ff, s6_c3_ff, s6_c2_ff;
   logic [31:0] s7_adcp_ff, s7_temp_ff, s7_b_ff, s7_a_ff;
   logic [31:0] s8_temp_ff, s8_p_ff, s8_den_ff;

   logic [31:0] adct, adcp;
   assign adct = {12'd0, req_data.raw_temperature};
   assign adcp = {12'd0, req_data.raw_pressure};

   logic [31:0] a7_in, p8_in;
   always_comb begin
      logic [31:0] ax;
      ax = sra(s6_c3_ff, 3) + sra(s6_c2_ff, 1);
      ax = sra(ax, 18);
      a7_in = 32'((32768 + ax) * p1);
      p8_in = 32'(((32'd1048576 - s7_adcp_ff) - sra(s7_b_ff, 12)) * 32'd3125);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_adcp_ff <= adcp;
         s1_x_ff <= (adct >> 3) - (t1 << 1);
         s1_d_ff <= (adct >> 4) - t1;
         s2_adcp_ff <= s1_adcp_ff;
         s2_a_ff <= sra(32'(s1_x_ff * t2), 11);
         s2_dd_ff <= 32'(s1_d_ff * s1_d_ff);
         s3_adcp_ff <= s2_adcp_ff;
         s3_a_ff <= s2_a_ff;
         s3_b_ff <= 32'(sra(s2_dd_ff, 12) * t3);
         s4_adcp_ff <= s3_adcp_ff;
         s4_fine_ff <= s3_a_ff + sra(s3_b_ff, 14);
         s4_t5_ff <= 32'((s3_a_ff + sra(s3_b_ff, 14)) * 32'd5);
         s5_adcp_ff <= s4_adcp_ff;
         s5_temp_ff <= sra(s4_t5_ff + 32'd128, 8);
         s5_a_ff <= sra(s4_fine_ff, 1) - 32'd64000;
         s5_sq_ff <= 32'(sra(sra(s4_fine_ff, 1) - 32'd64000, 2)
                       * sra(sra(s4_fine_ff, 1) - 32'd64000, 2));
         s6_adcp_ff <= s5_adcp_ff;
         s6_temp_ff <= s5_temp_ff;
         s6_b6_ff <= 32'(sra(s5_sq_ff, 11) * p6);
         s6_b5_ff <= 32'(s5_a_ff * p5);
         s6_c3_ff <= 32'(p3 * sra(s5_sq_ff, 13));
         s6_c2_ff <= 32'(p2 * s5_a_ff);
         s7_adcp_ff <= s6_adcp_ff;
         s7_temp_ff <= s6_temp_ff;
         s7_b_ff <= sra(s6_b6_ff + (s6_b5_ff << 1), 2) + (p4 << 16);
         s7_a_ff <= sra(a7_in, 15);
         s8_temp_ff <= s7_temp_ff;
         s8_p_ff <= p8_in;
         s8_den_ff <= s7_a_ff;
      end
   end

   // dividend doubled unless bit 31 is set; that branch doubles the quotient instead
   logic [31:0] div_num, quo;
   logic hi_ff [DivStages];
   logic [31:0] temp_d_ff [DivStages];
   logic zero_d_ff [DivStages];
   assign div_num = s8_p_ff[31] ? s8_p_ff : (s8_p_ff << 1);

   ptc_divider u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .dividend(div_num), .divisor(s8_den_ff), .quotient(quo)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         hi_ff[0] <= s8_p_ff[31];
         temp_d_ff[0] <= s8_temp_ff;
         zero_d_ff[0] <= (s8_den_ff == 32'd0);
         for (int s = 1; s < DivStages; s++) begin
            hi_ff[s] <= hi_ff[s-1];
            temp_d_ff[s] <= temp_d_ff[s-1];
            zero_d_ff[s] <= zero_d_ff[s-1];
         end
      end
   end

   // back section
   logic [31:0] q1_p_ff, q1_temp_ff, q1_qq_ff;
   logic q1_z_ff;
   logic [31:0] q2_p_ff, q2_temp_ff, q2_a_ff, q2_b_ff;
   logic q2_z_ff;
   logic [31:0] q3_p_ff, q3_temp_ff;
   logic q3_z_ff;
   rsp_type out_ff;

   logic [31:0] pq, pqs;
   assign pq = hi_ff[DivStages-1] ? (quo << 1) : quo;
   assign pqs = pq >> 3;

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_p_ff <= pq;
         q1_temp_ff <= temp_d_ff[DivStages-1];
         q1_z_ff <= zero_d_ff[DivStages-1];
         q1_qq_ff <= 32'(pqs * pqs);
         q2_p_ff <= q1_p_ff;
         q2_temp_ff <= q1_temp_ff;
         q2_z_ff <= q1_z_ff;
         q2_a_ff <= 32'(p9 * (q1_qq_ff >> 13));
         q2_b_ff <= 32'((q1_p_ff >> 2) * p8);
         q3_temp_ff <= q2_temp_ff;
         q3_z_ff <= q2_z_ff;
         q3_p_ff <= q2_p_ff
                  + sra(sra(q2_a_ff, 12) + sra(q2_b_ff, 13) + p7, 4);
         out_ff.temperature_centi <= q3_temp_ff;
         out_ff.pressure_pa <= q3_z_ff ? 32'd0 : q3_p_ff;
         out_ff.divide_guard <= q3_z_ff;
      end
   end

   assign rsp_data = out_ff;
endmodule

FILE: rtl/ptc_checker.sv
`include "pressure_temperature_compensation_assert.svh"
module ptc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input ptc_pkg::rsp_type rsp_data
);
   `PTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat dropped or changed")
   `PTC_ASSERT_IMP(a_guard_zero, clock, reset, rsp_valid && rsp_data.divide_guard, rsp_data.pressure_pa == 32'd0, "guard with nonzero pressure")
   `PTC_ASSERT_IMP(a_ready_free, clock, reset, !rsp_valid, req_ready, "stall without pending result")
   `PTC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result after reset")
endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
